>>> src/srfc_pkg.sv
// srfc_pkg: shared types, constants and the bytewise crc-16 update
// for the sensor response frame checker; no dependencies
`timescale 1ns / 1ps

package srfc_pkg;

	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam int          BYTE_W       = 8;
	localparam int          WORD_W       = 16;
	localparam int          POS_W        = 3;
	localparam int          PAYLOAD_LEN  = 6;
	localparam logic [2:0]  POS_FIRST    = 3'd0;
	localparam logic [2:0]  POS_CRC_LOW  = 3'd6;
	localparam logic [2:0]  POS_CRC_HIGH = 3'd7;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;

	// one finished frame
	typedef struct packed {
		logic                crc_ok;
		byte_t               func_code;
		byte_t               register_count;
		logic [WORD_W-1:0]   humidity_tenths;
		logic [WORD_W-1:0]   temperature_tenths;
	} result_t;

	// step control from the input stage into the framing logic
	typedef struct packed {
		logic take;
		logic start;
	} step_t;

	// reflected crc-16, eight shift steps for one byte
	function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
		input byte_t data);
		logic [WORD_W-1:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/srfc_frame.sv
// srfc_frame: byte position, running crc and stored frame bytes
// depends on srfc_pkg
`timescale 1ns / 1ps

module srfc_frame
	import srfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  step_t   step,
	input  byte_t   data,
	output logic    last,
	output result_t result
);

	pos_t              pos_q;
	logic [WORD_W-1:0] crc_q;
	byte_t             payload_q [PAYLOAD_LEN];
	byte_t             crc_low_q;

	pos_t              pos_eff;
	logic [WORD_W-1:0] crc_eff;
	logic              in_payload;

	// a start flag restarts framing with this byte
	assign pos_eff    = step.start ? POS_FIRST : pos_q;
	assign crc_eff    = step.start ? CRC_INIT : crc_q;
	assign in_payload = pos_eff < POS_CRC_LOW;
	assign last       = pos_eff == POS_CRC_HIGH;

	assign result.crc_ok             = {data, crc_low_q} == crc_eff;
	assign result.func_code          = payload_q[0];
	assign result.register_count     = payload_q[1];
	assign result.humidity_tenths    = {payload_q[2], payload_q[3]};
	assign result.temperature_tenths = {payload_q[4], payload_q[5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
			crc_q <= CRC_INIT;
		end else if (step.take) begin
			if (last) begin
				pos_q <= POS_FIRST;
				crc_q <= CRC_INIT;
			end else begin
				pos_q <= pos_eff + 3'd1;
				if (in_payload) begin
					crc_q <= crc_byte(crc_eff, data);
				end else begin
					crc_q <= crc_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.take && in_payload) begin
			payload_q[pos_eff] <= data;
		end
		if (step.take && pos_eff == POS_CRC_LOW) begin
			crc_low_q <= data;
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step.take && last |=> pos_q == POS_FIRST && crc_q == CRC_INIT)
		else $error("framing not restarted after last byte");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step.take && !last |=> pos_q == $past(pos_eff) + 3'd1)
		else $error("byte position did not advance");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step.take |=> $stable(pos_q) && $stable(crc_q))
		else $error("frame state changed without a byte");

endmodule

>>> src/srfc_out_reg.sv
// srfc_out_reg: result register holding one finished frame for the output side
// depends on srfc_pkg
`timescale 1ns / 1ps

module srfc_out_reg
	import srfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_valid,
	output logic    load_ready,
	input  result_t load_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			data_q <= load_data;
		end
	end

endmodule

>>> src/sensor_response_frame_checker_core.sv
// sensor_response_frame_checker_core: crc-16 frame check of an 8-byte sensor reply
// depends on srfc_pkg, srfc_frame, srfc_out_reg
//
//   channel | signals                                         | role
//   --------+-------------------------------------------------+-----------------------
//   in      | in_valid, in_ready, rx_byte, frame_start        | one reply byte
//   out     | out_valid, out_ready, crc_ok, func_code,        | one result per frame
//           | register_count, humidity_tenths,                |
//           | temperature_tenths                              |
//
// one byte per cycle sustained unless a waiting result stalls; a transaction passes
// the input register, then the crc/framing logic, and a frame's result enters the
// result register at the edge at which its eighth byte leaves the input register
// reset clears the byte position to zero, the crc to all ones and both valid flags
// a waiting result stalls only an eighth byte and the input behind it; other bytes
// keep flowing
`timescale 1ns / 1ps

module sensor_response_frame_checker_core
	import srfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  byte_t               rx_byte,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                crc_ok,
	output byte_t               func_code,
	output byte_t               register_count,
	output logic [WORD_W-1:0]   humidity_tenths,
	output logic [WORD_W-1:0]   temperature_tenths
);

	// input register
	logic    valid_s1;
	byte_t   rx_byte_s1;
	logic    frame_start_s1;

	logic    last;
	logic    res_ready;
	logic    advance;
	step_t   step;
	result_t frame_res;
	result_t out_res;

	// the byte in the input register moves on unless it ends a frame and the
	// result register is still full
	assign advance  = valid_s1 && (!last || res_ready);
	assign in_ready = !valid_s1 || advance;

	assign step.take  = advance;
	assign step.start = frame_start_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1     <= rx_byte;
			frame_start_s1 <= frame_start;
		end
	end

	// position, crc and stored bytes
	srfc_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (rx_byte_s1),
		.last   (last),
		.result (frame_res)
	);

	// result register; loads only when an eighth byte goes through
	srfc_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1 && last),
		.load_ready (res_ready),
		.load_data  (frame_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_res)
	);

	assign crc_ok             = out_res.crc_ok;
	assign func_code          = out_res.func_code;
	assign register_count     = out_res.register_count;
	assign humidity_tenths    = out_res.humidity_tenths;
	assign temperature_tenths = out_res.temperature_tenths;

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> last && out_valid && !out_ready)
		else $error("input stage stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last |=> out_valid)
		else $error("finished frame did not reach the result register");

endmodule
